// ----- design/cwes_pkg.sv -----
`default_nettype none
package cwes_pkg;

  localparam int ETA_W   = 4;
  localparam int PHI_W   = 2;
  localparam int ET_W    = 18;
  localparam int SUM_W   = 25;
  localparam int SIDE_W  = 21;
  localparam int DEF_W   = 3;
  localparam int LAYER_W = 3;
  localparam int LAYERS  = 5;
  localparam int COLS    = 3;
  localparam int SHIFT_W = 21;
  localparam int BOUND_W = 20;

  localparam logic [ETA_W-1:0] ETA_ROWS         = 4'd13;
  localparam logic [ETA_W-1:0] SHORT_ETA_ROWS   = 4'd3;
  localparam logic [ETA_W-1:0] CORE_ETA_LO      = 4'd3;
  localparam logic [ETA_W-1:0] CORE_ETA_HI      = 4'd9;
  localparam logic [ETA_W-1:0] WIDE_ETA_LO      = 4'd2;
  localparam logic [ETA_W-1:0] WIDE_ETA_HI      = 4'd10;
  localparam logic [ETA_W-1:0] SHORT_CENTER_ETA = 4'd1;
  localparam logic [ETA_W-1:0] LONG_CENTER_ETA  = 4'd6;

  localparam logic [PHI_W-1:0] PHI_LOW    = 2'd0;
  localparam logic [PHI_W-1:0] PHI_CENTER = 2'd1;
  localparam logic [PHI_W-1:0] PHI_HIGH   = 2'd2;
  localparam logic [PHI_W-1:0] COL_NONE   = 2'd3;

  localparam logic [LAYER_W-1:0] LAYER_PRE    = 3'd0;
  localparam logic [LAYER_W-1:0] LAYER_FRONT  = 3'd1;
  localparam logic [LAYER_W-1:0] LAYER_MIDDLE = 3'd2;
  localparam logic [LAYER_W-1:0] LAYER_BACK   = 3'd3;
  localparam logic [LAYER_W-1:0] LAYER_HAD    = 3'd4;

  localparam logic [DEF_W-1:0] DEF_1   = 3'd0;
  localparam logic [DEF_W-1:0] DEF_2   = 3'd1;
  localparam logic [DEF_W-1:0] DEF_3   = 3'd2;
  localparam logic [DEF_W-1:0] DEF_3A  = 3'd3;
  localparam logic [DEF_W-1:0] DEF_4   = 3'd4;
  localparam logic [DEF_W-1:0] DEF_5   = 3'd5;
  localparam logic [DEF_W-1:0] DEF_6   = 3'd6;
  localparam logic [DEF_W-1:0] DEF_ALL = 3'd7;

  localparam logic signed [SUM_W:0]  SUM_MAX  = 26'sd16777215;
  localparam logic signed [SUM_W:0]  SUM_MIN  = -26'sd16777216;
  localparam logic signed [SIDE_W:0] SIDE_MAX = 22'sd1048575;
  localparam logic signed [SIDE_W:0] SIDE_MIN = -22'sd1048576;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_CENTER = 2'd1,
    MODE_PAIR   = 2'd2
  } mode_t;

  typedef struct packed {
    logic signed [ET_W-1:0]  et;
    logic [PHI_W-1:0]        col;
    logic signed [ET_W-1:0]  side_et;
  } lane_t;

  typedef struct packed {
    logic signed [SHIFT_W-1:0] shift;
    logic [BOUND_W-1:0]        lo;
    logic [BOUND_W-1:0]        hi;
  } col_step_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]  col0;
    logic signed [SUM_W-1:0]  col1;
    logic signed [SUM_W-1:0]  col2;
    logic signed [SIDE_W-1:0] upper;
    logic signed [SIDE_W-1:0] lower;
  } fin_t;

  function automatic mode_t window_mode(logic [DEF_W-1:0] def, logic [LAYER_W-1:0] layer,
                                        logic [ETA_W-1:0] eta, logic [PHI_W-1:0] phi);
    logic  is_short;
    logic  core;
    logic  wide;
    logic  row1;
    mode_t m;
    is_short = (layer == LAYER_PRE) || (layer == LAYER_BACK) || (layer == LAYER_HAD);
    core     = (eta > CORE_ETA_LO) && (eta < CORE_ETA_HI);
    wide     = (eta > WIDE_ETA_LO) && (eta < WIDE_ETA_HI);
    row1     = (eta == SHORT_CENTER_ETA);
    m        = MODE_NONE;
    case (def)
      DEF_1: begin
        if (layer == LAYER_PRE) m = (row1 && phi == PHI_CENTER) ? MODE_CENTER : MODE_NONE;
        else if (is_short) m = MODE_CENTER;
        else m = core ? MODE_CENTER : MODE_NONE;
      end
      DEF_2: begin
        if (is_short) m = MODE_CENTER;
        else if (layer == LAYER_FRONT) m = wide ? MODE_CENTER : MODE_NONE;
        else m = core ? MODE_CENTER : MODE_NONE;
      end
      DEF_3: begin
        if (layer == LAYER_HAD) m = MODE_CENTER;
        else if (is_short) m = row1 ? MODE_PAIR : MODE_NONE;
        else m = core ? MODE_PAIR : MODE_NONE;
      end
      DEF_3A: begin
        if (layer == LAYER_HAD) m = MODE_CENTER;
        else if (is_short) m = row1 ? MODE_CENTER : MODE_NONE;
        else m = core ? MODE_CENTER : MODE_NONE;
      end
      DEF_4: begin
        if (layer == LAYER_HAD) m = MODE_NONE;
        else if (is_short) m = row1 ? MODE_PAIR : MODE_NONE;
        else m = core ? MODE_PAIR : MODE_NONE;
      end
      DEF_5: begin
        if (layer == LAYER_PRE) m = row1 ? MODE_PAIR : MODE_NONE;
        else if (is_short) m = MODE_NONE;
        else m = core ? MODE_PAIR : MODE_NONE;
      end
      DEF_6: begin
        if (is_short) m = MODE_NONE;
        else m = core ? MODE_PAIR : MODE_NONE;
      end
      DEF_ALL: m = MODE_CENTER;
      default: m = MODE_CENTER;
    endcase
    if (is_short && eta >= SHORT_ETA_ROWS) m = MODE_NONE;
    return m;
  endfunction

endpackage
`default_nettype wire

// ----- design/cwes_lane.sv -----
`default_nettype none
module cwes_lane #(
  parameter logic [2:0] LAYER = 3'd0
) (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic [cwes_pkg::DEF_W-1:0]         def,
  input  wire logic [cwes_pkg::ETA_W-1:0]         eta,
  input  wire logic [cwes_pkg::PHI_W-1:0]         phi,
  input  wire logic signed [cwes_pkg::ET_W-1:0]   et,
  output cwes_pkg::lane_t                         q
);
  import cwes_pkg::*;

  lane_t q_next;
  mode_t mode;
  logic  row_ok;
  logic  is_short;
  logic  side_hit;

  always_comb begin
    row_ok   = (eta < ETA_ROWS) && (phi != COL_NONE);
    is_short = (LAYER == LAYER_PRE) || (LAYER == LAYER_BACK) || (LAYER == LAYER_HAD);
    mode     = window_mode(def, LAYER, eta, phi);
    side_hit = row_ok && (phi != PHI_CENTER) &&
               (is_short ? (eta == SHORT_CENTER_ETA) : (eta == LONG_CENTER_ETA));
    q_next.et      = et;
    q_next.side_et = side_hit ? et : '0;
    case (mode)
      MODE_CENTER: q_next.col = row_ok ? PHI_CENTER : COL_NONE;
      MODE_PAIR:   q_next.col = row_ok ? phi : COL_NONE;
      default:     q_next.col = COL_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule
`default_nettype wire

// ----- design/cwes_merge.sv -----
`default_nettype none
module cwes_merge (
  input  wire logic                                  clk,
  input  wire logic                                  en,
  input  wire cwes_pkg::lane_t                       lanes [cwes_pkg::LAYERS],
  output cwes_pkg::col_step_t                        steps [cwes_pkg::COLS],
  output logic signed [cwes_pkg::SIDE_W-1:0]         side_add
);
  import cwes_pkg::*;

  col_step_t                 steps_next [COLS];
  logic signed [SIDE_W-1:0]  side_add_next;

  always_comb begin
    logic signed [ET_W-1:0]      a;
    logic signed [SHIFT_W-1:0]   shift;
    logic [BOUND_W-1:0]          lo;
    logic [BOUND_W-1:0]          hi;
    logic signed [BOUND_W+1:0]   lo_t;
    logic signed [BOUND_W+1:0]   hi_t;
    for (int c = 0; c < COLS; c++) begin
      shift = '0;
      lo    = '0;
      hi    = '0;
      for (int l = 0; l < LAYERS; l++) begin
        a     = (lanes[l].col == PHI_W'(c)) ? lanes[l].et : '0;
        shift = shift + SHIFT_W'(a);
        lo_t  = $signed({2'b00, lo}) + (BOUND_W+2)'(a);
        hi_t  = $signed({2'b00, hi}) - (BOUND_W+2)'(a);
        lo    = lo_t[BOUND_W+1] ? '0 : lo_t[BOUND_W-1:0];
        hi    = hi_t[BOUND_W+1] ? '0 : hi_t[BOUND_W-1:0];
      end
      steps_next[c].shift = shift;
      steps_next[c].lo    = lo;
      steps_next[c].hi    = hi;
    end
    side_add_next = '0;
    for (int l = 0; l < LAYERS; l++) begin
      side_add_next = side_add_next + SIDE_W'(lanes[l].side_et);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      steps    <= steps_next;
      side_add <= side_add_next;
    end
  end

endmodule
`default_nettype wire

// ----- design/cwes_accum.sv -----
`default_nettype none
module cwes_accum (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 en,
  input  wire logic                                 valid,
  input  wire logic                                 last,
  input  wire logic                                 up,
  input  wire cwes_pkg::col_step_t                  steps [cwes_pkg::COLS],
  input  wire logic signed [cwes_pkg::SIDE_W-1:0]   side_add,
  output logic                                      fin_valid,
  output cwes_pkg::fin_t                            fin
);
  import cwes_pkg::*;

  logic signed [SUM_W-1:0]   col      [COLS];
  logic signed [SUM_W-1:0]   col_next [COLS];
  logic signed [SIDE_W-1:0]  upper;
  logic signed [SIDE_W-1:0]  lower;
  logic signed [SIDE_W-1:0]  upper_next;
  logic signed [SIDE_W-1:0]  lower_next;

  always_comb begin
    logic signed [SUM_W:0]   s;
    logic signed [SUM_W:0]   lo_b;
    logic signed [SUM_W:0]   hi_b;
    logic signed [SIDE_W:0]  t;
    logic signed [SIDE_W-1:0] side_sat;
    for (int c = 0; c < COLS; c++) begin
      s    = (SUM_W+1)'(col[c]) + (SUM_W+1)'(steps[c].shift);
      lo_b = SUM_MIN + $signed({6'b0, steps[c].lo});
      hi_b = SUM_MAX - $signed({6'b0, steps[c].hi});
      if (s < lo_b) col_next[c] = lo_b[SUM_W-1:0];
      else if (s > hi_b) col_next[c] = hi_b[SUM_W-1:0];
      else col_next[c] = s[SUM_W-1:0];
    end
    t = (SIDE_W+1)'(up ? upper : lower) + (SIDE_W+1)'(side_add);
    if (t > SIDE_MAX) side_sat = SIDE_MAX[SIDE_W-1:0];
    else if (t < SIDE_MIN) side_sat = SIDE_MIN[SIDE_W-1:0];
    else side_sat = t[SIDE_W-1:0];
    upper_next = up ? side_sat : upper;
    lower_next = up ? lower : side_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
      upper     <= '0;
      lower     <= '0;
      for (int c = 0; c < COLS; c++) col[c] <= '0;
    end else if (en) begin
      fin_valid <= valid && last;
      if (valid) begin
        if (last) begin
          upper <= '0;
          lower <= '0;
          for (int c = 0; c < COLS; c++) col[c] <= '0;
        end else begin
          upper <= upper_next;
          lower <= lower_next;
          for (int c = 0; c < COLS; c++) col[c] <= col_next[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && valid && last) begin
      fin.col0  <= col_next[0];
      fin.col1  <= col_next[1];
      fin.col2  <= col_next[2];
      fin.upper <= upper_next;
      fin.lower <= lower_next;
    end
  end

endmodule
`default_nettype wire

// ----- design/calo_window_energy_sum.sv -----
// Stages: five layer lanes, a merge stage, an accumulator, output reg.
// Throughput: one cell per cycle while no held result stalls the pipeline.
// Flow control: a held result (m_tvalid high, m_tready low) stalls every stage and s_tready.
// Reset: rst (synchronous) clears reco_definition, the running sums and every valid flag.
`default_nettype none
module calo_window_energy_sum (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // eta_row[3:0], phi_col[5:4], presampler_et[23:6], front_et[41:24],
  // middle_et[59:42], back_et[77:60], hadronic_et[95:78]
  input  wire logic [95:0] s_tdata,
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // window_et[24:0], phi_flipped[25], zero[31:26]
  output logic [31:0]      m_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import cwes_pkg::*;

  localparam int ET_LSB = ETA_W + PHI_W;

  logic [DEF_W-1:0]          reco_definition;
  logic                      en;
  logic                      v1;
  logic                      v2;
  logic                      last1;
  logic                      last2;
  logic                      up1;
  logic                      up2;
  lane_t                     lanes [LAYERS];
  col_step_t                 steps [COLS];
  logic signed [SIDE_W-1:0]  side_add;
  logic                      fin_valid;
  fin_t                      fin;
  logic signed [SUM_W-1:0]   window_et;
  logic                      phi_flipped;
  logic signed [SUM_W-1:0]   window_et_next;
  logic                      phi_flipped_next;

  assign pready   = 1'b1;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign prdata   = (paddr[2] == 1'b0) ? 32'(reco_definition) : '0;
  assign m_tdata  = {6'b0, phi_flipped, window_et};

  always_ff @(posedge clk) begin
    if (rst) begin
      reco_definition <= DEF_1;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      reco_definition <= pwdata[DEF_W-1:0];
    end
  end

  for (genvar l = 0; l < LAYERS; l++) begin : g_lane
    cwes_lane #(
      .LAYER(LAYER_W'(l))
    ) u_lane (
      .clk (clk),
      .en  (en),
      .def (reco_definition),
      .eta (s_tdata[ETA_W-1:0]),
      .phi (s_tdata[ETA_W +: PHI_W]),
      .et  ($signed(s_tdata[ET_LSB + ET_W*l +: ET_W])),
      .q   (lanes[l])
    );
  end

  cwes_merge u_merge (
    .clk      (clk),
    .en       (en),
    .lanes    (lanes),
    .steps    (steps),
    .side_add (side_add)
  );

  cwes_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid     (v2),
    .last      (last2),
    .up        (up2),
    .steps     (steps),
    .side_add  (side_add),
    .fin_valid (fin_valid),
    .fin       (fin)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last1 <= s_tlast;
      up1   <= (s_tdata[ETA_W +: PHI_W] == PHI_HIGH);
      last2 <= last1;
      up2   <= up1;
    end
  end

  always_comb begin
    logic signed [SUM_W:0]   t0;
    logic signed [SUM_W:0]   t2;
    logic signed [SUM_W-1:0] s0;
    logic signed [SUM_W-1:0] s2;
    t0 = (SUM_W+1)'(fin.col1) + (SUM_W+1)'(fin.col0);
    t2 = (SUM_W+1)'(fin.col1) + (SUM_W+1)'(fin.col2);
    if (t0 > SUM_MAX) s0 = SUM_MAX[SUM_W-1:0];
    else if (t0 < SUM_MIN) s0 = SUM_MIN[SUM_W-1:0];
    else s0 = t0[SUM_W-1:0];
    if (t2 > SUM_MAX) s2 = SUM_MAX[SUM_W-1:0];
    else if (t2 < SUM_MIN) s2 = SUM_MIN[SUM_W-1:0];
    else s2 = t2[SUM_W-1:0];
    phi_flipped_next = fin.upper > fin.lower;
    window_et_next   = phi_flipped_next ? s2 : s0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      window_et   <= window_et_next;
      phi_flipped <= phi_flipped_next;
    end
  end

endmodule
`default_nettype wire
